### src/b2r_pkg.sv
// ----------------------------------------------------------------------------
// b2r_pkg: shared types and constants for the binary to radix digit converter
// Holds the number width, digit store geometry, radix limits and the
// command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package b2r_pkg;

   // number width, 1..64
   localparam int WIDTH        = 64;
   localparam int VALUE_W      = 64;
   localparam int BIT_W        = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   // digit store
   localparam int DIGIT_W      = 4;
   localparam int STORE_DEPTH  = 64;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W        = $clog2(STORE_DEPTH + 1);

   // radix register
   localparam int RADIX_W      = 5;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_STORE,
      ST_READ,
      ST_SHOW
   } b2r_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic store;
      logic rd_dec;
   } b2r_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic step_last;
      logic quot_zero;
      logic store_full;
      logic rd_zero;
   } b2r_status_type;

endpackage

### src/binary_to_radix_digits.sv
// ----------------------------------------------------------------------------
// binary_to_radix_digits: unsigned binary to radix digit converter
// Converts one number per request item into digit items, most significant
// digit first, with the final digit flagged.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one 64-bit value per item, taken when req_valid and !req_stall.
//            Only the low WIDTH bits are converted.
//   rsp_*  : one item per digit (0..radix-1), rsp_last_digit on the final,
//            least significant digit. Zero converts to the single digit 0.
//   csr_*  : radix write (2..16; 0,1 act as 2 and 17..31 act as 16). Write
//            only while the block is idle. csr_ready is always high.
// Sequence, for a result of D digits (D <= 64):
//   Each digit takes one division pass over all WIDTH bits in the shared
//   bit-serial divider plus a store step, so conversion runs D passes
//   after the accept. Readout then does a store RAM read, then a present,
//   for each digit.
//   One number is in flight at a time; req_stall is high until the final
//   digit is taken.
// Reset puts the radix at 10 and the block idle. A stalled rsp holds its
// digit and flag until taken.
// ----------------------------------------------------------------------------
module binary_to_radix_digits (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [b2r_pkg::VALUE_W-1:0]         req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [b2r_pkg::DIGIT_W-1:0]         rsp_digit,
   output logic                                rsp_last_digit,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [b2r_pkg::RADIX_W-1:0]         csr_data
);

   b2r_pkg::b2r_cmd_type    cmd;
   b2r_pkg::b2r_status_type status;

   assign csr_ready = 1'b1;

   b2r_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   b2r_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr         (csr_valid & csr_ready),
      .csr_data       (csr_data),
      .req_value      (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_digit      (rsp_digit),
      .rsp_last_digit (rsp_last_digit)
   );

`ifndef SYNTHESIS
   // no new request is taken while digits are being delivered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken during digit readout");

   // an accepted request never shows a digit in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("digit shown right after request accept");

   // after the final digit is taken, readout stops and input opens
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_digit) |=> (!rsp_valid && !req_stall))
      else $error("readout continued past final digit");
`endif

endmodule

### src/b2r_ram.sv
// ----------------------------------------------------------------------------
// b2r_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module b2r_ram #(
   parameter int DATA_W = 4,
   parameter int DEPTH  = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/b2r_ctrl.sv
// ----------------------------------------------------------------------------
// b2r_ctrl: sequencer for the digit converter
// Runs the division passes, stores each digit, then reads the digits back
// most significant first and presents them one item at a time.
// ----------------------------------------------------------------------------
module b2r_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output b2r_pkg::b2r_cmd_type    cmd,
   input  b2r_pkg::b2r_status_type status
);

   b2r_pkg::b2r_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b2r_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      case (state_ff)
         b2r_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = b2r_pkg::ST_DIVIDE;
            end
         end
         b2r_pkg::ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.step_last) begin
               state_in = b2r_pkg::ST_STORE;
            end
         end
         b2r_pkg::ST_STORE: begin
            cmd.store = 1'b1;
            // another pass while the quotient is nonzero and the store has room
            if (!status.quot_zero && !status.store_full) begin
               state_in = b2r_pkg::ST_DIVIDE;
            end else begin
               state_in = b2r_pkg::ST_READ;
            end
         end
         b2r_pkg::ST_READ: begin
            state_in = b2r_pkg::ST_SHOW;
         end
         b2r_pkg::ST_SHOW: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.rd_zero) begin
                  state_in = b2r_pkg::ST_IDLE;
               end else begin
                  cmd.rd_dec = 1'b1;
                  state_in   = b2r_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = b2r_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### src/b2r_dpath.sv
// ----------------------------------------------------------------------------
// b2r_dpath: datapath of the digit converter
// Radix register, bit-serial restoring divider, digit store and the
// read pointer that walks the digits back out.
// ----------------------------------------------------------------------------
module b2r_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr,
   input  logic [b2r_pkg::RADIX_W-1:0]         csr_data,
   input  logic [b2r_pkg::VALUE_W-1:0]         req_value,
   input  b2r_pkg::b2r_cmd_type                cmd,
   output b2r_pkg::b2r_status_type             status,
   output logic [b2r_pkg::DIGIT_W-1:0]         rsp_digit,
   output logic                                rsp_last_digit
);

   logic [b2r_pkg::RADIX_W-1:0] radix_ff;
   logic [b2r_pkg::RADIX_W-1:0] base;
   logic [b2r_pkg::WIDTH-1:0]   quot_ff, quot_in;
   logic [b2r_pkg::RADIX_W-1:0] rem_ff, rem_in;
   logic [b2r_pkg::BIT_W-1:0]   bit_ff, bit_in;
   logic [b2r_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [b2r_pkg::ADDR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [b2r_pkg::RADIX_W-1:0] shifted;
   logic                        q_bit;

   // radix register
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= b2r_pkg::RADIX_RESET;
      end else if (csr_wr) begin
         radix_ff <= csr_data;
      end
   end

   // clamp radix to 2..16
   always_comb begin
      if (radix_ff < b2r_pkg::RADIX_MIN) begin
         base = b2r_pkg::RADIX_MIN;
      end else if (radix_ff > b2r_pkg::RADIX_MAX) begin
         base = b2r_pkg::RADIX_MAX;
      end else begin
         base = radix_ff;
      end
   end

   // one restoring division step: shift in the top dividend bit
   assign shifted = {rem_ff[b2r_pkg::RADIX_W-2:0], quot_ff[b2r_pkg::WIDTH-1]};
   assign q_bit   = (shifted >= base);

   // divider, digit count and read pointer
   always_comb begin
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      bit_in    = bit_ff;
      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      if (cmd.load) begin
         quot_in  = req_value[b2r_pkg::WIDTH-1:0];
         rem_in   = '0;
         bit_in   = '0;
         count_in = '0;
      end else if (cmd.step) begin
         // quotient bits enter at the bottom as dividend bits leave the top
         quot_in = b2r_pkg::WIDTH'({quot_ff, q_bit});
         rem_in  = q_bit ? (shifted - base) : shifted;
         bit_in  = bit_ff + 1'b1;
      end else if (cmd.store) begin
         rem_in    = '0;
         bit_in    = '0;
         count_in  = count_ff + 1'b1;
         rd_ptr_in = count_ff[b2r_pkg::ADDR_W-1:0];
      end else if (cmd.rd_dec) begin
         rd_ptr_in = rd_ptr_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff   <= '0;
         rem_ff    <= '0;
         bit_ff    <= '0;
         count_ff  <= '0;
         rd_ptr_ff <= '0;
      end else begin
         quot_ff   <= quot_in;
         rem_ff    <= rem_in;
         bit_ff    <= bit_in;
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // digit store, least significant digit at address 0
   b2r_ram #(
      .DATA_W (b2r_pkg::DIGIT_W),
      .DEPTH  (b2r_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (count_ff[b2r_pkg::ADDR_W-1:0]),
      .wr_data (rem_ff[b2r_pkg::DIGIT_W-1:0]),
      .rd_addr (rd_ptr_ff),
      .rd_data (rsp_digit)
   );

   // status back to the controller
   assign status.step_last  = (bit_ff == b2r_pkg::BIT_W'(b2r_pkg::WIDTH - 1));
   assign status.quot_zero  = (quot_ff == '0);
   assign status.store_full = (count_ff == b2r_pkg::CNT_W'(b2r_pkg::STORE_DEPTH - 1));
   assign status.rd_zero    = (rd_ptr_ff == '0);

   assign rsp_last_digit = status.rd_zero;

endmodule

### tb/binary_to_radix_digits_tb.sv
// ----------------------------------------------------------------------------
// binary_to_radix_digits_tb: self-checking bench for the radix digit converter
// Sends numbers under a range of radix settings (in range, clamped low and
// clamped high), predicts the digit items of each accepted number and checks
// every digit item, in order, against that prediction. Both channels idle
// at random.
// ----------------------------------------------------------------------------

// one expected digit item
typedef struct {
   logic [b2r_pkg::DIGIT_W-1:0] digit;
   logic                        is_last;
} digit_item_type;

// prediction of the digit items and comparison against what the block sends
class digit_scoreboard_type;
   logic [b2r_pkg::RADIX_W-1:0] radix;
   digit_item_type              digits_due[$];
   int                          faults;

   function new();
      radix  = b2r_pkg::RADIX_RESET;
      faults = 0;
   endfunction

   function void set_radix(input logic [b2r_pkg::RADIX_W-1:0] r);
      radix = r;
   endfunction

   function int pending();
      return digits_due.size();
   endfunction

   // convert one accepted number, most significant digit first
   function void note_value(input logic [b2r_pkg::VALUE_W-1:0] value);
      logic [63:0]                 rest;
      logic [63:0]                 base;
      logic [b2r_pkg::DIGIT_W-1:0] digits[$];
      digit_item_type              item;
      base = (radix < b2r_pkg::RADIX_MIN) ? 64'(b2r_pkg::RADIX_MIN) :
             (radix > b2r_pkg::RADIX_MAX) ? 64'(b2r_pkg::RADIX_MAX) : 64'(radix);
      rest = 64'(value);
      if (b2r_pkg::WIDTH < 64)
         rest = rest & ((64'd1 << b2r_pkg::WIDTH) - 64'd1);
      // zero still yields one digit
      do begin
         digits.push_front(b2r_pkg::DIGIT_W'(rest % base));
         rest = rest / base;
      end while (rest != 0);
      foreach (digits[k]) begin
         item.digit   = digits[k];
         item.is_last = (k == digits.size() - 1);
         digits_due.insert(digits_due.size(), item);
      end
   endfunction

   function void flag_error(input string what, input digit_item_type want,
                            input digit_item_type got);
      faults++;
      if (faults <= 10)
         $display("%s: expected digit %0d last %0b, got digit %0d last %0b",
                  what, want.digit, want.is_last, got.digit, got.is_last);
   endfunction

   // compare one accepted digit item with the oldest expectation
   function void check_digit(input logic [b2r_pkg::DIGIT_W-1:0] digit,
                             input logic is_last);
      digit_item_type got;
      digit_item_type want;
      got.digit   = digit;
      got.is_last = is_last;
      if (digits_due.size() == 0) begin
         want.digit   = 'x;
         want.is_last = 1'bx;
         flag_error("digit item with nothing expected", want, got);
      end else begin
         want = digits_due.pop_front();
         if (got.digit !== want.digit || got.is_last !== want.is_last)
            flag_error("digit mismatch", want, got);
      end
   endfunction
endclass

module binary_to_radix_digits_tb;

   // generous bound: every item 64 digits with long stalls, many times over
   localparam longint RUN_LIMIT = 64'd50_000_000;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [b2r_pkg::VALUE_W-1:0]     req_value;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [b2r_pkg::DIGIT_W-1:0]     rsp_digit;
   logic                            rsp_last_digit;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [b2r_pkg::RADIX_W-1:0]     csr_data;

   digit_scoreboard_type            board;
   bit                              calm;

   binary_to_radix_digits dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit      (rsp_digit),
      .rsp_last_digit (rsp_last_digit),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      if (calm)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // random number, mostly narrower than the full width to bound run time
   function automatic logic [b2r_pkg::VALUE_W-1:0] random_value();
      logic [63:0] v;
      int          bits;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: bits = 64;
         1: return '1;
         default: bits = $urandom_range(1, 64);
      endcase
      if (bits < 64)
         v = v & ((64'd1 << bits) - 64'd1);
      return b2r_pkg::VALUE_W'(v);
   endfunction

   // send one number; valid stays high after acceptance until the next call
   task automatic send_value(input logic [b2r_pkg::VALUE_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_value(value);
   endtask

   // hold off the sender until every digit item has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // radix change, only with the block idle
   task automatic write_radix(input logic [b2r_pkg::RADIX_W-1:0] r);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= r;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.set_radix(r);
   endtask

   // result side back-pressure
   initial begin
      int n;
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // digit item monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_digit(rsp_digit, rsp_last_digit);
   end

   // stimulus
   initial begin
      logic [b2r_pkg::RADIX_W-1:0] picks[7];
      logic [b2r_pkg::RADIX_W-1:0] r;
      board     = new();
      calm      = 1'b0;
      picks     = '{5'd2, 5'd16, 5'd3, 5'd31, 5'd0, 5'd1, 5'd17};
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reset radix, then clamped and extreme radix settings
      send_value(64'd0);
      send_value(64'd1);
      send_value(64'd9);
      send_value(64'd10);
      send_value(64'd99);
      send_value(64'd100);
      send_value('1);
      send_value(64'h8000_0000_0000_0000);
      // radix below two acts as two
      write_radix(5'd0);
      send_value(64'd0);
      send_value(64'd5);
      send_value('1);
      write_radix(5'd1);
      send_value(64'd7);
      send_value(64'd0);
      // radix above sixteen acts as sixteen
      write_radix(5'd17);
      send_value(64'd255);
      send_value('1);
      write_radix(5'd31);
      send_value('1);
      send_value(64'd0);
      write_radix(5'd16);
      send_value('1);
      send_value(64'h0123_4567_89ab_cdef);
      write_radix(5'd2);
      send_value(64'd0);
      send_value(64'd1);
      send_value('1);

      // random phases, each under its own radix
      for (int p = 0; p < 10; p++) begin
         r = (p < 7) ? picks[p] : b2r_pkg::RADIX_W'($urandom_range(0, 31));
         write_radix(r);
         calm = ($urandom_range(0, 3) == 0);
         repeat (12) begin
            if ($urandom_range(0, 9) == 0)
               drain_results();
            send_value(random_value());
         end
      end
      calm = 1'b0;

      // wind down
      drain_results();
      repeat (300) @(posedge clock);
      if (board.faults == 0 && board.pending() == 0)
         $display("binary_to_radix_digits regression: pass");
      else
         $display("binary_to_radix_digits regression: fail");
      $finish;
   end

   // run time limit
   initial begin
      #(RUN_LIMIT);
      $display("binary_to_radix_digits regression: fail");
      $finish;
   end

endmodule
